### rtl/mono_block_frame_pixel_packer_assert.svh
// Assertion macros shared by the frame pixel packer RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef MONO_BLOCK_FRAME_PIXEL_PACKER_ASSERT_SVH
`define MONO_BLOCK_FRAME_PIXEL_PACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MBFP_ASSERT(lbl, clk, rst, cond, check) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
      else $error("mbfp: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define MBFP_ASSERT_NEXT(lbl, clk, rst, cond, check) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
      else $error("mbfp: next-cycle check failed");

`endif

### rtl/mbfp_pkg.sv
// Package for the frame pixel packer: panel geometry, codes and the stage record.
// No dependencies.
`default_nettype none

package mbfp_pkg;

   // Panel geometry
   localparam int PANEL_WIDTH  = 400;
   localparam int PANEL_HEIGHT = 300;
   localparam int TILE_ROWS    = PANEL_HEIGHT / 4;
   localparam int FRAME_BYTES  = (PANEL_WIDTH / 2) * TILE_ROWS;
   localparam int ADDR_W       = $clog2(FRAME_BYTES);

   // Field and internal widths
   localparam int IN_COORD_W = 12;
   localparam int COORD_W    = 11;
   localparam int AREA_W     = 2 * COORD_W;
   localparam int IDX_W      = 20;
   localparam int COUNT_W    = 21;
   localparam int PIXEL_W    = 16;
   localparam int RADDR_W    = 17;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int OP_W       = 3;

   localparam logic [PIXEL_W-1:0] WHITE_LEVEL = 16'h7fff;
   localparam logic signed [IN_COORD_W-1:0] WIDTH_S  = IN_COORD_W'(PANEL_WIDTH);
   localparam logic signed [IN_COORD_W-1:0] HEIGHT_S = IN_COORD_W'(PANEL_HEIGHT);

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CHANGED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STRAY     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_READ      = 3'd5;

   // Operations carried from decode into the update stage
   localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
   localparam logic [OP_W-1:0] OP_BEGIN_OK   = 3'd1;
   localparam logic [OP_W-1:0] OP_BEGIN_BAD  = 3'd2;
   localparam logic [OP_W-1:0] OP_PIXEL      = 3'd3;
   localparam logic [OP_W-1:0] OP_PIXEL_LAST = 3'd4;
   localparam logic [OP_W-1:0] OP_STRAY      = 3'd5;
   localparam logic [OP_W-1:0] OP_READ       = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        mask;
      logic              white;
      logic              in_range;
   } stage_type;

endpackage

`default_nettype wire

### rtl/mbfp_frame_ram.sv
// Frame store: single-write, single-read RAM with registered read data and
// the post-reset sweep that paints every byte white. Uses mbfp_pkg.
`default_nettype none
`include "mono_block_frame_pixel_packer_assert.svh"

module mbfp_frame_ram
   import mbfp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data,
   output logic                   clear_busy
);

   logic [7:0]        mem [0:FRAME_BYTES-1];
   logic              clear_ff;
   logic              clear_in;
   logic [ADDR_W-1:0] clear_cnt_ff;
   logic [ADDR_W-1:0] clear_cnt_in;
   logic [7:0]        rd_data_ff;
   logic              we;
   logic [ADDR_W-1:0] wa;
   logic [7:0]        wd;

   // Clear sweep counter
   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + ADDR_W'(1);
         if (clear_cnt_ff == ADDR_W'(FRAME_BYTES - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Write port shared between sweep and pixel updates
   assign we = clear_ff | wr_en;
   assign wa = clear_ff ? clear_cnt_ff : wr_addr;
   assign wd = clear_ff ? 8'hff : wr_data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_ff;

   // No request traffic may touch the store while it is being cleared
   `MBFP_ASSERT(a_no_access_in_clear, clock, reset, clear_ff, !rd_en && !wr_en)

endmodule

`default_nettype wire

### rtl/mbfp_area_ctrl.sv
// Request decode: rectangle checks, raster cursor and frame address generation.
// Uses mbfp_pkg; feeds the update stage and the frame RAM read port.
`default_nettype none
`include "mono_block_frame_pixel_packer_assert.svh"

module mbfp_area_ctrl
   import mbfp_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic        [KIND_W-1:0]     req_kind,
   input  wire logic signed [IN_COORD_W-1:0] req_x_first,
   input  wire logic signed [IN_COORD_W-1:0] req_y_first,
   input  wire logic signed [IN_COORD_W-1:0] req_x_last,
   input  wire logic signed [IN_COORD_W-1:0] req_y_last,
   input  wire logic        [COUNT_W-1:0]    req_pixel_total,
   input  wire logic        [PIXEL_W-1:0]    req_pixel_value,
   input  wire logic        [RADDR_W-1:0]    req_read_address,
   output stage_type                         stage
);

   logic [COORD_W-1:0] cursor_col_ff, cursor_col_in;
   logic [COORD_W-1:0] cursor_row_ff, cursor_row_in;
   logic [COORD_W-1:0] area_left_ff, area_left_in;
   logic [COORD_W-1:0] area_right_ff, area_right_in;
   logic [COORD_W-1:0] area_bottom_ff, area_bottom_in;
   logic               area_active_ff, area_active_in;

   logic signed [IN_COORD_W-1:0] span_x;
   logic signed [IN_COORD_W-1:0] span_y;
   logic [COORD_W-1:0] rect_w;
   logic [COORD_W-1:0] rect_h;
   logic [AREA_W-1:0]  rect_area;
   logic               rect_bad;
   logic               count_ok;
   logic [COORD_W-1:0] flip_row;
   logic [IDX_W-1:0]   pix_idx;
   logic               pix_in_range;
   logic               pix_last;
   logic               rd_in_range;

   // Rectangle checks for begin requests
   assign rect_bad = (req_x_first < 0) || (req_y_first < 0) ||
                     (req_x_last < req_x_first) || (req_y_last < req_y_first) ||
                     (req_x_last >= WIDTH_S) || (req_y_last >= HEIGHT_S);
   assign span_x    = req_x_last - req_x_first;
   assign span_y    = req_y_last - req_y_first;
   assign rect_w    = span_x[COORD_W-1:0] + COORD_W'(1);
   assign rect_h    = span_y[COORD_W-1:0] + COORD_W'(1);
   assign rect_area = AREA_W'(rect_w) * AREA_W'(rect_h);
   assign count_ok  = (AREA_W'(req_pixel_total) == rect_area);

   // Tile address of the cursor pixel, rows flipped vertically
   assign flip_row     = COORD_W'(PANEL_HEIGHT - 1) - cursor_row_ff;
   assign pix_idx      = IDX_W'(cursor_col_ff[COORD_W-1:1]) * IDX_W'(TILE_ROWS) +
                         IDX_W'(flip_row[COORD_W-1:2]);
   assign pix_in_range = (pix_idx < IDX_W'(FRAME_BYTES));
   assign pix_last     = (cursor_col_ff >= area_right_ff) &&
                         (cursor_row_ff >= area_bottom_ff);
   assign rd_in_range  = (req_read_address < RADDR_W'(FRAME_BYTES));

   // Request decode and cursor advance
   always_comb begin
      stage          = '0;
      cursor_col_in  = cursor_col_ff;
      cursor_row_in  = cursor_row_ff;
      area_left_in   = area_left_ff;
      area_right_in  = area_right_ff;
      area_bottom_in = area_bottom_ff;
      area_active_in = area_active_ff;
      unique case (req_kind)
         KIND_BEGIN: begin
            area_active_in = 1'b0;
            stage.op       = OP_BEGIN_BAD;
            if (!rect_bad && count_ok) begin
               area_active_in = 1'b1;
               area_left_in   = req_x_first[COORD_W-1:0];
               area_right_in  = req_x_last[COORD_W-1:0];
               area_bottom_in = req_y_last[COORD_W-1:0];
               cursor_col_in  = req_x_first[COORD_W-1:0];
               cursor_row_in  = req_y_first[COORD_W-1:0];
               stage.op       = OP_BEGIN_OK;
            end
         end
         KIND_PIXEL: begin
            if (!area_active_ff) begin
               stage.op = OP_STRAY;
            end else begin
               stage.op       = pix_last ? OP_PIXEL_LAST : OP_PIXEL;
               stage.in_range = pix_in_range;
               stage.addr     = pix_in_range ? pix_idx[ADDR_W-1:0] : '0;
               stage.mask     = 8'h80 >> {flip_row[1:0], cursor_col_ff[0]};
               stage.white    = (req_pixel_value >= WHITE_LEVEL);
               if (pix_last) begin
                  area_active_in = 1'b0;
               end else if (cursor_col_ff >= area_right_ff) begin
                  cursor_col_in = area_left_ff;
                  cursor_row_in = cursor_row_ff + COORD_W'(1);
               end else begin
                  cursor_col_in = cursor_col_ff + COORD_W'(1);
               end
            end
         end
         KIND_READ: begin
            stage.op       = OP_READ;
            stage.in_range = rd_in_range;
            stage.addr     = rd_in_range ? req_read_address[ADDR_W-1:0] : '0;
         end
         default: begin
            stage.op = OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff  <= '0;
         cursor_row_ff  <= '0;
         area_left_ff   <= '0;
         area_right_ff  <= '0;
         area_bottom_ff <= '0;
         area_active_ff <= 1'b0;
      end else if (accept) begin
         cursor_col_ff  <= cursor_col_in;
         cursor_row_ff  <= cursor_row_in;
         area_left_ff   <= area_left_in;
         area_right_ff  <= area_right_in;
         area_bottom_ff <= area_bottom_in;
         area_active_ff <= area_active_in;
      end
   end

   // Cursor stays inside the open rectangle
   `MBFP_ASSERT(a_cursor_in_area, clock, reset, area_active_ff,
      cursor_col_ff >= area_left_ff && cursor_col_ff <= area_right_ff &&
      cursor_row_ff <= area_bottom_ff)
   // Last pixel closes the area
   `MBFP_ASSERT_NEXT(a_last_closes, clock, reset,
      accept && stage.op == OP_PIXEL_LAST, !area_active_ff)

endmodule

`default_nettype wire

### rtl/mbfp_update.sv
// Update stage: read-modify-write of the frame byte with write forwarding,
// change tracking and the response register. Uses mbfp_pkg.
`default_nettype none
`include "mono_block_frame_pixel_packer_assert.svh"

module mbfp_update
   import mbfp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire stage_type           stage_in,
   input  wire logic [7:0]          rd_data,
   output logic                     s1_free,
   output logic                     wr_en,
   output logic      [ADDR_W-1:0]   wr_addr,
   output logic      [7:0]          wr_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [7:0]          rsp_read_byte
);

   logic                s1_valid_ff;
   stage_type           s1_ff;
   logic                fwd_hit_ff;
   logic [7:0]          fwd_data_ff;
   logic                any_changed_ff, any_changed_in;
   logic                out_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [7:0]          out_byte_ff;

   logic [7:0]          cur_byte;
   logic [7:0]          new_byte;
   logic                changed;
   logic                has_rsp;
   logic [STATUS_W-1:0] status;
   logic [7:0]          byte_out;
   logic                is_pixel;
   logic                out_free;
   logic                s1_adv;

   // Byte being modified: forwarded if the previous write hit the same entry
   assign cur_byte = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign new_byte = s1_ff.white ? (cur_byte | s1_ff.mask) : (cur_byte & ~s1_ff.mask);
   assign changed  = s1_ff.in_range && (new_byte != cur_byte);
   assign is_pixel = (s1_ff.op == OP_PIXEL) || (s1_ff.op == OP_PIXEL_LAST);

   // Result selection
   always_comb begin
      has_rsp        = 1'b1;
      status         = ST_ACCEPTED;
      byte_out       = 8'h00;
      any_changed_in = any_changed_ff;
      case (s1_ff.op)
         OP_BEGIN_OK: begin
            status         = ST_ACCEPTED;
            any_changed_in = 1'b0;
         end
         OP_BEGIN_BAD: status = ST_INVALID;
         OP_PIXEL: begin
            has_rsp        = 1'b0;
            any_changed_in = any_changed_ff | changed;
         end
         OP_PIXEL_LAST: begin
            any_changed_in = any_changed_ff | changed;
            status         = (any_changed_ff | changed) ? ST_CHANGED : ST_UNCHANGED;
         end
         OP_STRAY: status = ST_STRAY;
         OP_READ: begin
            status   = ST_READ;
            byte_out = s1_ff.in_range ? cur_byte : 8'h00;
         end
         default: has_rsp = 1'b0;
      endcase
   end

   // Stage advance and write back
   assign out_free = !out_valid_ff || rsp_ready;
   assign s1_adv   = s1_valid_ff && (!has_rsp || out_free);
   assign s1_free  = !s1_valid_ff || s1_adv;
   assign wr_en    = s1_adv && is_pixel && s1_ff.in_range;
   assign wr_addr  = s1_ff.addr;
   assign wr_data  = new_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         fwd_hit_ff     <= 1'b0;
         any_changed_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_hit_ff  <= wr_en && (wr_addr == stage_in.addr);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
            fwd_hit_ff  <= 1'b0;
         end
         if (s1_adv) begin
            any_changed_ff <= any_changed_in;
         end
         if (s1_adv && has_rsp) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= stage_in;
         fwd_data_ff <= wr_data;
      end
      if (s1_adv && has_rsp) begin
         out_status_ff <= status;
         out_byte_ff   <= byte_out;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_read_byte = out_byte_ff;

   // A forwarded byte always belongs to the request held in the stage
   `MBFP_ASSERT(a_fwd_with_stage, clock, reset, fwd_hit_ff, s1_valid_ff)
   // Only read responses carry frame data
   `MBFP_ASSERT(a_byte_only_on_read, clock, reset,
      out_valid_ff && out_status_ff != ST_READ, out_byte_ff == 8'h00)

endmodule

`default_nettype wire

### rtl/mono_block_frame_pixel_packer.sv
// Rate: one request per clock, pixels included, whenever the response side keeps
// up. Each request is decoded and its frame byte read at the edge that takes it;
// the update stage then modifies the byte and writes it back when it advances,
// forwarding the previous write when two pixels share one tile byte, and any
// response is registered in the output register at that advance. The frame RAM
// has a single port pair (one read, one write). After reset the frame store is
// swept to white, one byte per cycle, over all 15000 bytes (the frame size);
// req_ready stays low until the sweep is done.
//
// Top level of the frame pixel packer. Uses mbfp_pkg, mbfp_area_ctrl,
// mbfp_frame_ram and mbfp_update.
`default_nettype none

module mono_block_frame_pixel_packer
   import mbfp_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic        [KIND_W-1:0]     req_kind,
   input  wire logic signed [IN_COORD_W-1:0] req_x_first,
   input  wire logic signed [IN_COORD_W-1:0] req_y_first,
   input  wire logic signed [IN_COORD_W-1:0] req_x_last,
   input  wire logic signed [IN_COORD_W-1:0] req_y_last,
   input  wire logic        [COUNT_W-1:0]    req_pixel_total,
   input  wire logic        [PIXEL_W-1:0]    req_pixel_value,
   input  wire logic        [RADDR_W-1:0]    req_read_address,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic             [STATUS_W-1:0]   rsp_status,
   output logic             [7:0]            rsp_read_byte
);

   logic              accept;
   logic              clear_busy;
   logic              s1_free;
   stage_type         stage;
   logic [7:0]        rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   // Request handshake
   assign req_ready = !clear_busy && s1_free;
   assign accept    = req_valid && req_ready;

   mbfp_area_ctrl u_area_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_kind         (req_kind),
      .req_x_first      (req_x_first),
      .req_y_first      (req_y_first),
      .req_x_last       (req_x_last),
      .req_y_last       (req_y_last),
      .req_pixel_total  (req_pixel_total),
      .req_pixel_value  (req_pixel_value),
      .req_read_address (req_read_address),
      .stage            (stage)
   );

   mbfp_frame_ram u_frame_ram (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (accept),
      .rd_addr    (stage.addr),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   mbfp_update u_update (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .stage_in      (stage),
      .rd_data       (rd_data),
      .s1_free       (s1_free),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_read_byte (rsp_read_byte)
   );

endmodule

`default_nettype wire

### sim/tb_mono_block_frame_pixel_packer.sv
// Self-checking testbench for the frame pixel packer: directed and random requests,
// checked against a shadow frame store kept in the bench. Uses mbfp_pkg and the
// mono_block_frame_pixel_packer RTL.
`timescale 1ns / 1ps

module tb_mono_block_frame_pixel_packer;
   import mbfp_pkg::*;

   localparam int IDLE_PCT     = 31;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int SETTLE_TICKS = 16;
   localparam int RANDOM_ITEMS = 600;
   localparam int BURST_ITEMS  = 120;
   localparam int NOISE_ITEMS  = 200;
   localparam int STALL_CYCLES = 400;
   localparam int MAX_PRINTED  = 100;

   typedef enum int {LEVEL_RANDOM, LEVEL_WHITE, LEVEL_BLACK, LEVEL_EDGE} level_mode_type;

   typedef struct {
      logic [KIND_W-1:0]            kind;
      logic signed [IN_COORD_W-1:0] x_first;
      logic signed [IN_COORD_W-1:0] y_first;
      logic signed [IN_COORD_W-1:0] x_last;
      logic signed [IN_COORD_W-1:0] y_last;
      logic [COUNT_W-1:0]           pixel_total;
      logic [PIXEL_W-1:0]           pixel_value;
      logic [RADDR_W-1:0]           read_address;
   } pack_req_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [7:0]          read_byte;
   } status_rec_type;

   // DUT ports
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic        [KIND_W-1:0]     req_kind = '0;
   logic signed [IN_COORD_W-1:0] req_x_first = '0;
   logic signed [IN_COORD_W-1:0] req_y_first = '0;
   logic signed [IN_COORD_W-1:0] req_x_last = '0;
   logic signed [IN_COORD_W-1:0] req_y_last = '0;
   logic        [COUNT_W-1:0]    req_pixel_total = '0;
   logic        [PIXEL_W-1:0]    req_pixel_value = '0;
   logic        [RADDR_W-1:0]    req_read_address = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic        [STATUS_W-1:0]   rsp_status;
   logic        [7:0]            rsp_read_byte;

   // Bench state
   pack_req_type   req_queue[$];
   pack_req_type   current_req;
   logic           driving = 1'b0;
   status_rec_type status_due[$];
   status_rec_type oldest_due;
   logic           no_idle = 1'b0;
   int             rsp_hold_left = 0;
   int             sent_items = 0;
   int             error_count = 0;

   // Shadow copy of the frame store and the area cursor
   logic [7:0]  shadow_frame [FRAME_BYTES];
   int          cur_col, cur_row, area_left, area_right, area_bottom;
   logic        area_open, any_changed;

   mono_block_frame_pixel_packer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_x_first      (req_x_first),
      .req_y_first      (req_y_first),
      .req_x_last       (req_x_last),
      .req_y_last       (req_y_last),
      .req_pixel_total  (req_pixel_total),
      .req_pixel_value  (req_pixel_value),
      .req_read_address (req_read_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_read_byte    (rsp_read_byte)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit: the reset sweep plus all requests take well under a tenth of this
   initial begin
      #2_000_000;
      $display("mono_block_frame_pixel_packer: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      // keep the log short if the block is badly broken
      if (error_count < MAX_PRINTED) $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Byte index of a panel pixel: column-major tiles, rows flipped
   function automatic int tile_address(input int x, input int y);
      return (x / 2) * TILE_ROWS + (PANEL_HEIGHT - 1 - y) / 4;
   endfunction

   // Computes the response of one accepted request and updates the shadow state
   function automatic void predict_status(input pack_req_type r);
      int             x1, y1, x2, y2, yf, idx, bit_pos;
      logic [7:0]     mask, prev, next_byte;
      status_rec_type e;
      e.status    = ST_ACCEPTED;
      e.read_byte = 8'h00;
      case (r.kind)
         KIND_BEGIN: begin
            x1 = r.x_first;
            y1 = r.y_first;
            x2 = r.x_last;
            y2 = r.y_last;
            area_open = 1'b0;
            if (x1 < 0 || y1 < 0 || x2 < x1 || y2 < y1 ||
                x2 >= PANEL_WIDTH || y2 >= PANEL_HEIGHT) begin
               e.status = ST_INVALID;
            end else if (int'(r.pixel_total) != (x2 - x1 + 1) * (y2 - y1 + 1)) begin
               e.status = ST_INVALID;
            end else begin
               area_left   = x1;
               area_right  = x2;
               area_bottom = y2;
               cur_col     = x1;
               cur_row     = y1;
               any_changed = 1'b0;
               area_open   = 1'b1;
               e.status    = ST_ACCEPTED;
            end
            status_due.push_back(e);
         end
         KIND_PIXEL: begin
            if (!area_open) begin
               e.status = ST_STRAY;
               status_due.push_back(e);
            end else begin
               yf      = PANEL_HEIGHT - 1 - cur_row;
               idx     = (cur_col / 2) * TILE_ROWS + yf / 4;
               bit_pos = 7 - ((yf % 4) * 2 + cur_col % 2);
               mask    = 8'h01 << bit_pos;
               if (idx < FRAME_BYTES) begin
                  prev      = shadow_frame[idx];
                  next_byte = (r.pixel_value >= WHITE_LEVEL) ? (prev | mask) : (prev & ~mask);
                  shadow_frame[idx] = next_byte;
                  if (next_byte != prev) any_changed = 1'b1;
               end
               // advance in raster order; the last pixel closes the area
               if (cur_col >= area_right) begin
                  if (cur_row >= area_bottom) begin
                     area_open = 1'b0;
                     e.status  = any_changed ? ST_CHANGED : ST_UNCHANGED;
                     status_due.push_back(e);
                  end else begin
                     cur_col = area_left;
                     cur_row = cur_row + 1;
                  end
               end else begin
                  cur_col = cur_col + 1;
               end
            end
         end
         KIND_READ: begin
            e.status = ST_READ;
            if (r.read_address < FRAME_BYTES) e.read_byte = shadow_frame[r.read_address];
            status_due.push_back(e);
         end
         default: ;
      endcase
   endfunction

   // Request builders; fields the kind does not use carry random junk
   function automatic pack_req_type random_req();
      pack_req_type r;
      r.kind         = KIND_W'($urandom_range(0, 3));
      r.x_first      = IN_COORD_W'($urandom);
      r.y_first      = IN_COORD_W'($urandom);
      r.x_last       = IN_COORD_W'($urandom);
      r.y_last       = IN_COORD_W'($urandom);
      r.pixel_total  = COUNT_W'($urandom);
      r.pixel_value  = PIXEL_W'($urandom);
      r.read_address = RADDR_W'($urandom);
      return r;
   endfunction

   function automatic pack_req_type begin_req(input int x1, input int y1, input int x2,
                                              input int y2, input int count);
      pack_req_type r;
      r             = random_req();
      r.kind        = KIND_BEGIN;
      r.x_first     = IN_COORD_W'(x1);
      r.y_first     = IN_COORD_W'(y1);
      r.x_last      = IN_COORD_W'(x2);
      r.y_last      = IN_COORD_W'(y2);
      r.pixel_total = COUNT_W'(count);
      return r;
   endfunction

   function automatic pack_req_type pixel_req(input int value);
      pack_req_type r;
      r             = random_req();
      r.kind        = KIND_PIXEL;
      r.pixel_value = PIXEL_W'(value);
      return r;
   endfunction

   function automatic pack_req_type read_req(input int addr);
      pack_req_type r;
      r              = random_req();
      r.kind         = KIND_READ;
      r.read_address = RADDR_W'(addr);
      return r;
   endfunction

   function automatic int pixel_level(input level_mode_type mode);
      case (mode)
         LEVEL_WHITE: return $urandom_range(int'(WHITE_LEVEL), 16'hffff);
         LEVEL_BLACK: return $urandom_range(0, int'(WHITE_LEVEL) - 1);
         LEVEL_EDGE:  return $urandom_range(0, 1) ? int'(WHITE_LEVEL) : int'(WHITE_LEVEL) - 1;
         default:     return $urandom_range(0, 16'hffff);
      endcase
   endfunction

   // Queue one request; the driver process keeps at most two waiting
   task automatic send_request(input pack_req_type r);
      req_queue.push_back(r);
      sent_items++;
      while (req_queue.size() >= 2) @(posedge clock);
   endtask

   // One area sequence, mostly well formed, sometimes broken or abandoned
   task automatic send_random_area();
      int             w, h, x1, y1, x2, y2, count, pix, shape;
      level_mode_type mode;
      shape = $urandom_range(0, 99);
      w     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
      h     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
      x1    = $urandom_range(0, PANEL_WIDTH - w);
      y1    = $urandom_range(0, PANEL_HEIGHT - h);
      x2    = x1 + w - 1;
      y2    = y1 + h - 1;
      count = w * h;
      pix   = count;
      mode  = level_mode_type'($urandom_range(0, 3));
      if (shape < 6) begin
         // count one off from the area; following pixels are strays
         count = $urandom_range(0, 1) ? count + 1 : count - 1;
         pix   = 2;
      end else if (shape < 10) begin
         // runs past the bottom edge
         y2  = PANEL_HEIGHT - 1 + $urandom_range(1, 3);
         pix = 1;
      end else if (shape < 13) begin
         // inverted columns
         x2  = x1 - 1;
         pix = 1;
      end else if (shape < 23) begin
         // abandoned partway; the next begin drops it
         pix = $urandom_range(0, count - 1);
      end
      send_request(begin_req(x1, y1, x2, y2, count));
      repeat (pix) send_request(pixel_req(pixel_level(mode)));
      if (shape >= 23 && $urandom_range(0, 1)) begin
         send_request(read_req(tile_address(x1, y1)));
         send_request(read_req(tile_address(x2, y2)));
      end
   endtask

   // Accepted and rejected rectangles at the panel limits
   task automatic test_area_limits();
      send_request(begin_req(0, 0, PANEL_WIDTH - 1, PANEL_HEIGHT - 1,
                             PANEL_WIDTH * PANEL_HEIGHT));
      // each of these abandons whatever is open
      send_request(begin_req(5, 0, 4, 0, 0));
      send_request(begin_req(0, -2048, 3, 3, 4));
      send_request(begin_req(PANEL_WIDTH - 2, 0, PANEL_WIDTH, 0, 3));
      send_request(begin_req(0, 0, 0, 2047, 2048));
      send_request(begin_req(0, 0, 1, 1, (1 << COUNT_W) - 1));
   endtask

   // Stray pixel, unused kind and reads at and past the end of the store
   task automatic test_stray_and_reads();
      pack_req_type r;
      send_request(pixel_req(16'hffff));
      r      = random_req();
      r.kind = 2'd3;
      send_request(r);
      send_request(read_req(0));
      send_request(read_req(FRAME_BYTES - 1));
      send_request(read_req(FRAME_BYTES));
      send_request(read_req((1 << RADDR_W) - 1));
   endtask

   // White threshold on both sides, changed and unchanged areas in the corners
   task automatic test_pixel_levels();
      send_request(begin_req(0, 0, 1, 1, 4));
      send_request(pixel_req(16'h0000));
      send_request(pixel_req(int'(WHITE_LEVEL) - 1));
      send_request(pixel_req(int'(WHITE_LEVEL)));
      send_request(pixel_req(16'hffff));
      send_request(read_req(tile_address(0, 0)));
      send_request(begin_req(PANEL_WIDTH - 2, PANEL_HEIGHT - 2,
                             PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 4));
      repeat (4) send_request(pixel_req(16'hffff));
      send_request(read_req(tile_address(PANEL_WIDTH - 1, PANEL_HEIGHT - 1)));
      send_request(begin_req(PANEL_WIDTH - 1, 0, PANEL_WIDTH - 1, 0, 1));
      send_request(pixel_req(16'h0000));
   endtask

   task automatic test_random_areas();
      int target;
      target = sent_items + RANDOM_ITEMS;
      while (sent_items < target) send_random_area();
   endtask

   // Long stretch with neither side idling
   task automatic test_back_to_back();
      int target;
      target  = sent_items + BURST_ITEMS;
      no_idle = 1'b1;
      while (sent_items < target) send_random_area();
      no_idle = 1'b0;
   endtask

   // Receiver holds off while requests keep coming, so the input backs up
   task automatic test_response_stall();
      rsp_hold_left = STALL_CYCLES;
      repeat (20) send_request(read_req($urandom_range(0, FRAME_BYTES - 1)));
      repeat (3) send_random_area();
   endtask

   // Random fields everywhere, plus reads inside the frame
   task automatic test_noise();
      repeat (NOISE_ITEMS) begin
         if ($urandom_range(0, 9) < 3) send_request(read_req($urandom_range(0, FRAME_BYTES - 1)));
         else send_request(random_req());
      end
   endtask

   // Request driver: holds valid until accepted, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         driving = 1'b0;
      end else begin
         if (driving && req_ready) begin
            predict_status(current_req);
            driving = 1'b0;
         end
         if (!driving) begin
            if (req_queue.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
               current_req = req_queue.pop_front();
               req_kind         <= current_req.kind;
               req_x_first      <= current_req.x_first;
               req_y_first      <= current_req.y_first;
               req_x_last       <= current_req.x_last;
               req_y_last       <= current_req.y_last;
               req_pixel_total  <= current_req.pixel_total;
               req_pixel_value  <= current_req.pixel_value;
               req_read_address <= current_req.read_address;
               req_valid        <= 1'b1;
               driving = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side: random ready, long hold on demand, field checks
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               report_mismatch($sformatf("response status %0d with nothing outstanding",
                                         rsp_status));
            end else begin
               oldest_due = status_due.pop_front();
               if (rsp_status !== oldest_due.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_status, oldest_due.status));
               if (rsp_read_byte !== oldest_due.read_byte)
                  report_mismatch($sformatf("read_byte got %02h expected %02h",
                                            rsp_read_byte, oldest_due.read_byte));
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left = rsp_hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int drain_wait;
      // shadow state after reset
      foreach (shadow_frame[i]) shadow_frame[i] = 8'hff;
      cur_col     = 0;
      cur_row     = 0;
      area_left   = 0;
      area_right  = 0;
      area_bottom = 0;
      area_open   = 1'b0;
      any_changed = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_area_limits();
      test_stray_and_reads();
      test_pixel_levels();
      test_random_areas();
      test_back_to_back();
      test_response_stall();
      test_noise();

      // all requests accepted, then let the responses drain
      while (req_queue.size() > 0 || driving) @(posedge clock);
      drain_wait = 0;
      while (status_due.size() > 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_TICKS) @(posedge clock);
      if (status_due.size() > 0)
         report_mismatch($sformatf("%0d responses never arrived", status_due.size()));

      if (error_count == 0) begin
         $display("mono_block_frame_pixel_packer: match");
      end else begin
         $display("mono_block_frame_pixel_packer: mismatch");
      end
      $finish;
   end

endmodule
